@@ rtl/dsm_pkg.sv @@
// package for the surround to stereo downmix: types, constants and arithmetic helpers
`timescale 1ns / 1ps

package dsm_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int CHAN_IN            = 5;
    localparam int OPND_W             = 19;
    localparam int ACC_W              = 20;
    localparam int STEP_W             = 3;
    localparam int DEF_COEF_FRAC_BITS = 15;

    localparam logic [STEP_W-1:0] ISSUE_STEPS = 3'd6;
    localparam logic [STEP_W-1:0] MIX_LAST    = 3'd7;

    localparam logic [2:0] CH_FOUR = 3'd4;
    localparam logic [2:0] CH_FIVE = 3'd5;
    localparam logic [2:0] CH_SIX  = 3'd6;
    localparam logic [2:0] CH_RESET = 3'd2;

    // unsigned q0.32 gains
    localparam logic [63:0] Q32_CENTER   = 64'd3037000500;
    localparam logic [63:0] Q32_SIDE     = 64'd3744265682;
    localparam logic [63:0] Q32_SIDE_INV = 64'd2104095667;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 20'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -20'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_MIX,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_QUAD,
        MODE_SURR
    } mode_t;

    typedef struct packed {
        logic              capture;
        logic              mix_start;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              nbr_self;
        logic              load_out;
        logic              last;
        logic              shift_prev;
        logic              load_held;
    } dsm_cmd_t;

    typedef struct packed {
        logic eob;
        logic out_free;
    } dsm_stat_t;

    typedef struct packed {
        logic en;
        logic right;
        logic rear;
    } dsm_tag_t;

    // round q0.32 gain to q(frac)
    function automatic logic [63:0] q32_to_coef(input logic [63:0] q, input int frac);
        return (q + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    // 3 * current + neighbor
    function automatic logic signed [OPND_W-1:0] rear_sum(
        input logic signed [SAMPLE_W-1:0] cur,
        input logic signed [SAMPLE_W-1:0] nbr
    );
        logic signed [OPND_W-1:0] c;
        logic signed [OPND_W-1:0] n;
        c = {{(OPND_W-SAMPLE_W){cur[SAMPLE_W-1]}}, cur};
        n = {{(OPND_W-SAMPLE_W){nbr[SAMPLE_W-1]}}, nbr};
        return (c <<< 1) + c + n;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > SAT_MAX)
        begin
            return 16'sh7fff;
        end
        else if (v < SAT_MIN)
        begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

@@ rtl/dsm_ctrl.sv @@
// controller state machine: sequences capture, mixing steps and result loads
`timescale 1ns / 1ps

module dsm_ctrl
    import dsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dsm_stat_t stat,
    output dsm_cmd_t  cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              phase_reg;
    logic              phase_next;
    logic              holding_reg;
    logic              holding_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            holding_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            holding_reg <= holding_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        holding_next = holding_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = holding_reg ? ST_MIX : ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (stat.eob)
                begin
                    state_next = ST_MIX;
                    step_next  = '0;
                    phase_next = 1'b1;
                end
                else
                begin
                    holding_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MIX:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == MIX_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (!phase_reg && stat.eob)
                    begin
                        state_next = ST_MIX;
                        step_next  = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        holding_next = !phase_reg;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.capture    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mix_start  = (state_reg == ST_MIX) && (step_reg == '0);
        cmd.issue      = (state_reg == ST_MIX) && (step_reg < ISSUE_STEPS);
        cmd.step       = step_reg;
        cmd.nbr_self   = phase_reg;
        cmd.last       = phase_reg;
        unique case (state_reg)
            ST_ABSORB:
            begin
                cmd.load_held = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load_out   = stat.out_free;
                cmd.shift_prev = stat.out_free;
                cmd.load_held  = stat.out_free && !phase_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/dsm_datapath.sv @@
// datapath: frame storage, shared multiplier pipeline, accumulators and output register
`timescale 1ns / 1ps

module dsm_datapath
    import dsm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CHAN_IN*SAMPLE_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  dsm_cmd_t                     cmd,
    output dsm_stat_t                    stat,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [2*SAMPLE_W-1:0]        m_tdata,
    output logic                         m_tlast
);

    localparam int CW      = COEF_FRAC_BITS + 1;
    localparam int PW      = OPND_W + CW;
    localparam int SH_CTR  = COEF_FRAC_BITS;
    localparam int SH_REAR = COEF_FRAC_BITS + 2;

    localparam logic [CW-1:0] KC = CW'(q32_to_coef(Q32_CENTER, COEF_FRAC_BITS));
    localparam logic [CW-1:0] KS = CW'(q32_to_coef(Q32_SIDE, COEF_FRAC_BITS));
    localparam logic [CW-1:0] KI = CW'(q32_to_coef(Q32_SIDE_INV, COEF_FRAC_BITS));
    localparam logic [PW-1:0] BIAS_CTR  = PW'((64'd1 << SH_CTR) - 64'd1);
    localparam logic [PW-1:0] BIAS_REAR = PW'((64'd1 << SH_REAR) - 64'd1);

    logic [2:0]                 chan_cnt_reg;
    logic signed [SAMPLE_W-1:0] in_reg   [CHAN_IN];
    logic                       eob_reg;
    logic signed [SAMPLE_W-1:0] held_reg [CHAN_IN];
    logic signed [SAMPLE_W-1:0] prev_reg [2];

    mode_t                      mode;
    logic signed [SAMPLE_W-1:0] nbr0;
    logic signed [SAMPLE_W-1:0] nbr1;
    logic signed [OPND_W-1:0]   opnd_next;
    logic [CW-1:0]              coef_next;
    dsm_tag_t                   tag_next;

    logic signed [OPND_W-1:0]   opnd_reg;
    logic [CW-1:0]              coef_reg;
    dsm_tag_t                   tag1_reg;
    logic signed [PW-1:0]       prod_reg;
    dsm_tag_t                   tag2_reg;

    logic signed [PW-1:0]       biased;
    logic signed [PW-1:0]       shifted;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    acc_l_reg;
    logic signed [ACC_W-1:0]    acc_r_reg;

    logic signed [SAMPLE_W-1:0] out_r_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg;
    logic                       out_last_reg;
    logic                       out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= CH_RESET;
        end
        else if (cfg_wr_en)
        begin
            chan_cnt_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (chan_cnt_reg == CH_FIVE || chan_cnt_reg == CH_SIX)
        begin
            mode = MODE_SURR;
        end
        else if (chan_cnt_reg == CH_FOUR)
        begin
            mode = MODE_QUAD;
        end
        else
        begin
            mode = MODE_PASS;
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < CHAN_IN; i++)
            begin
                in_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eob_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            eob_reg <= s_tlast;
        end
    end

    // pending frame and the rears of the frame before it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_IN; i++)
            begin
                held_reg[i] <= '0;
            end
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end
        else
        begin
            if (cmd.shift_prev)
            begin
                prev_reg[0] <= held_reg[2];
                prev_reg[1] <= held_reg[3];
            end
            if (cmd.load_held)
            begin
                for (int i = 0; i < CHAN_IN; i++)
                begin
                    held_reg[i] <= in_reg[i];
                end
            end
        end
    end

    assign nbr0 = cmd.nbr_self ? held_reg[2] : in_reg[2];
    assign nbr1 = cmd.nbr_self ? held_reg[3] : in_reg[3];

    // operand, gain and destination for each step
    always_comb
    begin
        opnd_next = '0;
        coef_next = KC;
        tag_next  = '0;
        unique case (mode)
            MODE_SURR:
            begin
                unique case (cmd.step)
                    3'd0:
                    begin
                        opnd_next = rear_sum(held_reg[2], nbr0);
                        coef_next = KS;
                        tag_next  = '{en: 1'b1, right: 1'b0, rear: 1'b1};
                    end
                    3'd1:
                    begin
                        opnd_next = rear_sum(held_reg[2], prev_reg[0]);
                        coef_next = KI;
                        tag_next  = '{en: 1'b1, right: 1'b1, rear: 1'b1};
                    end
                    3'd2:
                    begin
                        opnd_next = rear_sum(held_reg[3], nbr1);
                        coef_next = KI;
                        tag_next  = '{en: 1'b1, right: 1'b0, rear: 1'b1};
                    end
                    3'd3:
                    begin
                        opnd_next = rear_sum(held_reg[3], prev_reg[1]);
                        coef_next = KS;
                        tag_next  = '{en: 1'b1, right: 1'b1, rear: 1'b1};
                    end
                    3'd4:
                    begin
                        opnd_next = {{(OPND_W-SAMPLE_W){held_reg[4][SAMPLE_W-1]}}, held_reg[4]};
                        tag_next  = '{en: 1'b1, right: 1'b0, rear: 1'b0};
                    end
                    3'd5:
                    begin
                        opnd_next = {{(OPND_W-SAMPLE_W){held_reg[4][SAMPLE_W-1]}}, held_reg[4]};
                        tag_next  = '{en: 1'b1, right: 1'b1, rear: 1'b0};
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_QUAD:
            begin
                unique case (cmd.step)
                    3'd0:
                    begin
                        opnd_next = rear_sum(held_reg[2], nbr0);
                        tag_next  = '{en: 1'b1, right: 1'b0, rear: 1'b1};
                    end
                    3'd1:
                    begin
                        opnd_next = rear_sum(held_reg[2], prev_reg[0]);
                        tag_next  = '{en: 1'b1, right: 1'b1, rear: 1'b1};
                    end
                    3'd2:
                    begin
                        opnd_next = {{(OPND_W-SAMPLE_W){held_reg[3][SAMPLE_W-1]}}, held_reg[3]};
                        tag_next  = '{en: 1'b1, right: 1'b0, rear: 1'b0};
                    end
                    3'd3:
                    begin
                        opnd_next = {{(OPND_W-SAMPLE_W){held_reg[3][SAMPLE_W-1]}}, held_reg[3]};
                        tag_next  = '{en: 1'b1, right: 1'b1, rear: 1'b0};
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (!cmd.issue)
        begin
            tag_next = '0;
        end
    end

    // operand stage, product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_next;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        coef_reg <= coef_next;
        prod_reg <= opnd_reg * $signed(coef_reg);
    end

    // truncate toward zero
    always_comb
    begin
        if (prod_reg[PW-1])
        begin
            biased = PW'(prod_reg + (tag2_reg.rear ? BIAS_REAR : BIAS_CTR));
        end
        else
        begin
            biased = prod_reg;
        end
        shifted = tag2_reg.rear ? (biased >>> SH_REAR) : (biased >>> SH_CTR);
        term    = shifted[ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mix_start)
        begin
            acc_l_reg <= {{(ACC_W-SAMPLE_W){held_reg[0][SAMPLE_W-1]}}, held_reg[0]};
            acc_r_reg <= {{(ACC_W-SAMPLE_W){held_reg[1][SAMPLE_W-1]}}, held_reg[1]};
        end
        else if (tag2_reg.en)
        begin
            if (tag2_reg.right)
            begin
                acc_r_reg <= acc_r_reg + term;
            end
            else
            begin
                acc_l_reg <= acc_l_reg + term;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_r_reg    <= sat16(acc_r_reg);
            out_l_reg    <= sat16(acc_l_reg);
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.eob      = eob_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {out_l_reg, out_r_reg};
    assign m_tlast       = out_last_reg;

endmodule

@@ rtl/surround_to_stereo_downmix.sv @@
// top level of the surround to stereo downmix
`timescale 1ns / 1ps
// a held frame's result is loaded into the output register once the next item is accepted and mixed with it
// a block's last frame gives its own result after a second mix pass, or after a single pass if nothing was held
// no new item is accepted until the current one has been held or its results have been loaded
// each mix pass runs the shared multiplier, and output stalls hold back the load of a result
// reset: channel_count returns to 2, held frame and previous rears clear, nothing held

module surround_to_stereo_downmix
    import dsm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // front_left, front_right, third_channel, fourth_channel, fifth_channel
    input  logic [CHAN_IN*SAMPLE_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // right_out, left_out
    output logic [2*SAMPLE_W-1:0]       m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_wr_data
);

    dsm_cmd_t  cmd;
    dsm_stat_t stat;

    dsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsm_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken item");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (m_tvalid && (m_tlast == $past(cmd.last))))
        else $error("loaded result not presented with its last flag");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready again right after an accepted item");

endmodule
